/* rtl/elb_pkg.sv */
// Shared constants and types for the ellipse bounds and metrics pipeline.
package elb_pkg;

  // Fixed-point constants, Q16: pi, 2*pi-5, pi-3
  localparam logic [17:0] PI_Q16 = 18'd205887;
  localparam logic [16:0] C1_Q16 = 17'd84095;
  localparam logic [13:0] C2_Q16 = 14'd9279;
  localparam logic [30:0] AXIS_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // Unit geometry
  localparam int unsigned SQRT_IN_W = 64;
  localparam int unsigned SQRT_OUT_W = SQRT_IN_W / 2;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned TRIG_LAT = 4;

  // Normalized ellipse carried down the pipeline
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        a;
    logic [30:0]        b;
    logic [15:0]        az;
    logic               empty;
  } pass_t;

  // Box edges plus what the output stage still needs
  typedef struct packed {
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic signed [31:0] y_min;
    logic signed [31:0] y_max;
    logic [30:0]        a;
    logic [30:0]        b;
    logic [15:0]        az;
    logic               empty;
  } box_t;

  // One finished result transaction
  typedef struct packed {
    logic signed [31:0] box_x_min;
    logic signed [31:0] box_x_max;
    logic signed [31:0] box_y_min;
    logic signed [31:0] box_y_max;
    logic [47:0]        area;
    logic [33:0]        perimeter;
    logic [30:0]        focus;
    logic [16:0]        ecc;
    logic               empty;
    logic [30:0]        major;
    logic [30:0]        minor;
    logic [15:0]        az;
  } res_t;

endpackage

/* rtl/elb_delay.sv */
// Enabled register chain that keeps side data aligned with the arithmetic units.
module elb_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [DEPTH];

  // Shift one place per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

/* rtl/elb_sin.sv */
// Four-stage polynomial |sin| of a 16-bit binary angle, Q16 result.
module elb_sin (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] ang,
  output logic [16:0] sin_mag
);
  import elb_pkg::*;

  logic [14:0] r;
  logic [16:0] z;
  logic [33:0] zz;
  logic [16:0] z_1_r, z2_1_r;
  logic [30:0] p2;
  logic [16:0] inner;
  logic [16:0] z_2_r, z2_2_r, inner_2_r;
  logic [33:0] p3;
  logic [17:0] mid;
  logic [16:0] z_3_r;
  logic [17:0] mid_3_r;
  logic [34:0] p4;
  logic [35:0] p4_rnd;
  logic [16:0] sin_r;

  // Quadrant fold: mirror odd quadrants
  assign r  = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
  assign z  = {r, 2'b00};
  assign zz = z * z;

  assign p2    = z2_1_r * C2_Q16;
  assign inner = C1_Q16 - {2'b00, p2[30:16]};

  assign p3  = z2_2_r * inner_2_r;
  assign mid = PI_Q16 - p3[33:16];

  assign p4     = z_3_r * mid_3_r;
  assign p4_rnd = {1'b0, p4} + 36'd65536;

  always_ff @(posedge clk) begin
    if (en) begin
      z_1_r     <= z;
      z2_1_r    <= zz[32:16];
      z_2_r     <= z_1_r;
      z2_2_r    <= z2_1_r;
      inner_2_r <= inner;
      z_3_r     <= z_2_r;
      mid_3_r   <= mid;
      sin_r     <= p4_rnd[33:17];
    end
  end

  assign sin_mag = sin_r;

endmodule

/* rtl/elb_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module elb_isqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [elb_pkg::SQRT_IN_W-1:0]   radicand,
  output logic [elb_pkg::SQRT_OUT_W-1:0]  root
);
  import elb_pkg::*;

  localparam int unsigned N  = SQRT_OUT_W;
  localparam int unsigned RW = SQRT_OUT_W + 2;

  logic [RW-1:0]        rem_r [N];
  logic [SQRT_IN_W-1:0] val_r [N];
  logic [N-1:0]         q_r   [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [RW-1:0]        rem_i;
    logic [SQRT_IN_W-1:0] val_i;
    logic [N-1:0]         q_i;
    logic [RW+1:0]        rem_sh, trial, diff;
    logic                 ge;

    if (g == 0) begin : g_first
      assign rem_i = '0;
      assign val_i = radicand;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[g-1];
      assign val_i = val_r[g-1];
      assign q_i   = q_r[g-1];
    end

    // Bring down two bits, try 4q+1
    assign rem_sh = {rem_i, val_i[SQRT_IN_W-1 -: 2]};
    assign trial  = {2'b00, q_i, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g]   <= {q_i[N-2:0], ge};
        rem_r[g] <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
        val_r[g] <= {val_i[SQRT_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root = q_r[N-1];

endmodule

/* rtl/elb_div.sv */
// Pipelined restoring divider for a fraction num/den below one, one bit per stage.
module elb_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [30:0]                   num,
  input  logic [30:0]                   den,
  output logic [elb_pkg::DIV_STEPS-1:0] quo
);
  import elb_pkg::*;

  localparam int unsigned N = DIV_STEPS;

  logic [30:0]  rem_r [N];
  logic [30:0]  den_r [N];
  logic [N-1:0] q_r   [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [30:0]  rem_i, den_i;
    logic [N-1:0] q_i;
    logic [31:0]  rem_sh, diff;
    logic         ge;

    if (g == 0) begin : g_first
      assign rem_i = num;
      assign den_i = den;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[g-1];
      assign den_i = den_r[g-1];
      assign q_i   = q_r[g-1];
    end

    assign rem_sh = {rem_i, 1'b0};
    assign ge     = (rem_sh >= {1'b0, den_i});
    assign diff   = rem_sh - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g]   <= {q_i[N-2:0], ge};
        rem_r[g] <= ge ? diff[30:0] : rem_sh[30:0];
        den_r[g] <= den_i;
      end
    end
  end

  assign quo = q_r[N-1];

endmodule

/* rtl/ellipse_bounds_and_metrics.sv */
// Top level: ellipse normalize, bounding box, area, perimeter, focus and eccentricity.
// Takes one ellipse per clock while in_ready is high and returns one result per ellipse,
// in order. The latency is set by the chain through the focus square root
// (32 stages, one root bit each) and the eccentricity divider (16 stages); the
// box and perimeter square roots run beside it. A two-entry output buffer holds
// finished results; in_ready drops only while both entries are occupied, and the
// whole pipeline then holds in place.
module ellipse_bounds_and_metrics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_axis_first,
  input  logic signed [31:0] in_axis_second,
  input  logic [15:0]        in_azimuth_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_box_x_min,
  output logic signed [31:0] out_box_x_max,
  output logic signed [31:0] out_box_y_min,
  output logic signed [31:0] out_box_y_max,
  output logic [47:0]        out_area_out,
  output logic [33:0]        out_perimeter_out,
  output logic [30:0]        out_focus_distance,
  output logic [16:0]        out_eccentricity_out,
  output logic               out_is_empty,
  output logic [30:0]        out_major_axis,
  output logic [30:0]        out_minor_axis,
  output logic [15:0]        out_azimuth_out
);
  import elb_pkg::*;

  // Stage numbers of the main events
  localparam int unsigned P_TRIG  = 1 + TRIG_LAT;
  localparam int unsigned P_ROOT  = 3 + SQRT_OUT_W;
  localparam int unsigned P_BOXSQ = 8 + SQRT_OUT_W;
  localparam int unsigned P_BOX   = P_BOXSQ + 1;
  localparam int unsigned P_PERIM = P_ROOT + 2;
  localparam int unsigned LAT     = P_ROOT + DIV_STEPS;

  function automatic logic [30:0] axis_mag(input logic signed [31:0] v);
    logic [31:0] neg;
    neg = 32'(-v);
    if (!v[31]) return v[30:0];
    if (neg[31]) return AXIS_MAX;
    return neg[30:0];
  endfunction

  function automatic logic signed [31:0] sat_edge(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -34'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic        adv;
  logic        accept;
  logic [LAT:1] vld_r;

  // ---------------- stage 1: magnitudes, swap, empty
  logic [30:0] mag_a, mag_b;
  logic        swap;
  pass_t       p1_nxt, p1_r;

  assign mag_a = axis_mag(in_axis_first);
  assign mag_b = axis_mag(in_axis_second);
  assign swap  = (mag_a < mag_b);

  always_comb begin
    p1_nxt.cx    = in_center_x;
    p1_nxt.cy    = in_center_y;
    p1_nxt.a     = swap ? mag_b : mag_a;
    p1_nxt.b     = swap ? mag_a : mag_b;
    p1_nxt.az    = swap ? (in_azimuth_in + QUARTER_TURN) : in_azimuth_in;
    p1_nxt.empty = (mag_a == '0) || (mag_b == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) p1_r <= p1_nxt;
  end

  // ---------------- stage 2: axis products and 3(a+b)
  logic [61:0] ab_r, aa_r, bb_r;
  logic [33:0] sum3_r;
  logic [32:0] apb;

  assign apb = {2'b00, p1_r.a} + {2'b00, p1_r.b};

  always_ff @(posedge clk) begin
    if (adv) begin
      ab_r   <= p1_r.a * p1_r.b;
      aa_r   <= p1_r.a * p1_r.a;
      bb_r   <= p1_r.b * p1_r.b;
      sum3_r <= {1'b0, apb} + {apb, 1'b0};
    end
  end

  // ---------------- stage 3: root operands and area
  logic [63:0] t4_nxt, t4_r, area_p;
  logic [61:0] fdiff_r;
  logic [47:0] area_r;
  logic [59:0] ab4, aa4, bb4;

  assign ab4    = ab_r[61:2];
  assign aa4    = aa_r[61:2];
  assign bb4    = bb_r[61:2];
  assign t4_nxt = {ab4, 3'b000} + {3'b000, ab4, 1'b0}
                + {3'b000, aa4, 1'b0} + {4'b0000, aa4}
                + {3'b000, bb4, 1'b0} + {4'b0000, bb4};
  assign area_p = ab_r[61:16] * PI_Q16;

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_r    <= t4_nxt;
      fdiff_r <= aa_r - bb_r;
      area_r  <= 48'((area_p + 64'd32768) >> 16);
    end
  end

  // ---------------- perimeter and focus roots
  logic [SQRT_OUT_W-1:0] proot, froot;

  elb_isqrt u_sqrt_perim (
    .clk(clk), .en(adv), .radicand(t4_r), .root(proot)
  );

  elb_isqrt u_sqrt_focus (
    .clk(clk), .en(adv), .radicand({2'b00, fdiff_r}), .root(froot)
  );

  // ---------------- perimeter tail
  logic [33:0] sum3_d, root2, d_r;
  logic [51:0] perim_p;
  logic [35:0] perim_s;
  logic [33:0] perim_r, perim_d;

  elb_delay #(.W(34), .DEPTH(P_ROOT - 2)) u_dly_sum3 (
    .clk(clk), .en(adv), .din(sum3_r), .dout(sum3_d)
  );

  assign root2   = {1'b0, proot, 1'b0};
  assign perim_p = d_r * PI_Q16;
  assign perim_s = 36'((perim_p + 52'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r     <= (sum3_d > root2) ? (sum3_d - root2) : '0;
      perim_r <= (perim_s > 36'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF : perim_s[33:0];
    end
  end

  elb_delay #(.W(34), .DEPTH(LAT - P_PERIM)) u_dly_perim (
    .clk(clk), .en(adv), .din(perim_r), .dout(perim_d)
  );

  // ---------------- eccentricity divider
  logic [30:0]          a_div, focus_d;
  logic [DIV_STEPS-1:0] quo;

  elb_delay #(.W(31), .DEPTH(P_ROOT - 1)) u_dly_adiv (
    .clk(clk), .en(adv), .din(p1_r.a), .dout(a_div)
  );

  elb_div u_div (
    .clk(clk), .en(adv), .num(froot[30:0]), .den(a_div), .quo(quo)
  );

  elb_delay #(.W(31), .DEPTH(DIV_STEPS)) u_dly_focus (
    .clk(clk), .en(adv), .din(froot[30:0]), .dout(focus_d)
  );

  // ---------------- area alignment
  logic [47:0] area_d;

  elb_delay #(.W(48), .DEPTH(LAT - 3)) u_dly_area (
    .clk(clk), .en(adv), .din(area_r), .dout(area_d)
  );

  // ---------------- trig and box half extents
  logic [16:0] s_mag, c_mag;
  logic [61:0] ab_trig;
  logic [30:0] a5, b5;

  elb_sin u_sin (.clk(clk), .en(adv), .ang(p1_r.az), .sin_mag(s_mag));
  elb_sin u_cos (.clk(clk), .en(adv), .ang(p1_r.az + QUARTER_TURN), .sin_mag(c_mag));

  elb_delay #(.W(62), .DEPTH(TRIG_LAT)) u_dly_ab (
    .clk(clk), .en(adv), .din({p1_r.a, p1_r.b}), .dout(ab_trig)
  );

  assign a5 = ab_trig[61:31];
  assign b5 = ab_trig[30:0];

  logic [48:0] as_p, ac_p, bs_p, bc_p;
  logic [30:0] as_r, ac_r, bs_r, bc_r;
  logic [61:0] as2_r, ac2_r, bs2_r, bc2_r;
  logic [62:0] hw_sq_r, hh_sq_r;

  assign as_p = (a5 * s_mag) + 49'd32768;
  assign ac_p = (a5 * c_mag) + 49'd32768;
  assign bs_p = (b5 * s_mag) + 49'd32768;
  assign bc_p = (b5 * c_mag) + 49'd32768;

  always_ff @(posedge clk) begin
    if (adv) begin
      as_r    <= as_p[46:16];
      ac_r    <= ac_p[46:16];
      bs_r    <= bs_p[46:16];
      bc_r    <= bc_p[46:16];
      as2_r   <= as_r * as_r;
      ac2_r   <= ac_r * ac_r;
      bs2_r   <= bs_r * bs_r;
      bc2_r   <= bc_r * bc_r;
      hw_sq_r <= {1'b0, as2_r} + {1'b0, bc2_r};
      hh_sq_r <= {1'b0, ac2_r} + {1'b0, bs2_r};
    end
  end

  logic [SQRT_OUT_W-1:0] hw, hh;

  elb_isqrt u_sqrt_hw (
    .clk(clk), .en(adv), .radicand({1'b0, hw_sq_r}), .root(hw)
  );

  elb_isqrt u_sqrt_hh (
    .clk(clk), .en(adv), .radicand({1'b0, hh_sq_r}), .root(hh)
  );

  // ---------------- box edges
  pass_t pbox;
  box_t  box_nxt, box_r, box_d;
  logic signed [33:0] cx34, cy34, hw34, hh34;

  elb_delay #(.W($bits(pass_t)), .DEPTH(P_BOXSQ - 1)) u_dly_pass (
    .clk(clk), .en(adv), .din(p1_r), .dout(pbox)
  );

  assign cx34 = {{2{pbox.cx[31]}}, pbox.cx};
  assign cy34 = {{2{pbox.cy[31]}}, pbox.cy};
  assign hw34 = {2'b00, hw};
  assign hh34 = {2'b00, hh};

  always_comb begin
    box_nxt.a     = pbox.a;
    box_nxt.b     = pbox.b;
    box_nxt.az    = pbox.az;
    box_nxt.empty = pbox.empty;
    if (pbox.empty) begin
      box_nxt.x_min = '0;
      box_nxt.x_max = '0;
      box_nxt.y_min = '0;
      box_nxt.y_max = '0;
    end else begin
      box_nxt.x_min = sat_edge(cx34 - hw34);
      box_nxt.x_max = sat_edge(cx34 + hw34);
      box_nxt.y_min = sat_edge(cy34 - hh34);
      box_nxt.y_max = sat_edge(cy34 + hh34);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) box_r <= box_nxt;
  end

  elb_delay #(.W($bits(box_t)), .DEPTH(LAT - P_BOX)) u_dly_box (
    .clk(clk), .en(adv), .din(box_r), .dout(box_d)
  );

  // ---------------- result assembly
  res_t res;

  always_comb begin
    res.box_x_min = box_d.x_min;
    res.box_x_max = box_d.x_max;
    res.box_y_min = box_d.y_min;
    res.box_y_max = box_d.y_max;
    res.area      = area_d;
    res.perimeter = perim_d;
    res.focus     = focus_d;
    res.ecc       = box_d.empty ? '0 : {1'b0, quo};
    res.empty     = box_d.empty;
    res.major     = box_d.a;
    res.minor     = box_d.b;
    res.az        = box_d.az;
  end

  // ---------------- valid chain
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-1:1], accept};
    end
  end

  // ---------------- two-entry output buffer
  res_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;
  assign push     = adv && vld_r[LAT];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  res_t head;
  assign head = ent_r[rd_ptr_r];

  assign out_valid            = (cnt_r != 2'd0);
  assign out_box_x_min        = head.box_x_min;
  assign out_box_x_max        = head.box_x_max;
  assign out_box_y_min        = head.box_y_min;
  assign out_box_y_max        = head.box_y_max;
  assign out_area_out         = head.area;
  assign out_perimeter_out    = head.perimeter;
  assign out_focus_distance   = head.focus;
  assign out_eccentricity_out = head.ecc;
  assign out_is_empty         = head.empty;
  assign out_major_axis       = head.major;
  assign out_minor_axis       = head.minor;
  assign out_azimuth_out      = head.az;

  // ---------------- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output buffer count out of range");

  a_axis_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_major_axis >= out_minor_axis)
    else $error("major axis below minor axis");

  a_focus_le_major: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_focus_distance <= out_major_axis)
    else $error("focus distance exceeds major axis");

  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_box_x_min == '0 && out_box_x_max == '0 &&
      out_box_y_min == '0 && out_box_y_max == '0 && out_eccentricity_out == '0)
    else $error("empty ellipse with nonzero box");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_x_min <= out_box_x_max && out_box_y_min <= out_box_y_max)
    else $error("box edges out of order");

endmodule

/* test/tb_ellipse_bounds_and_metrics.sv */
// Testbench for the ellipse bounds and metrics pipeline: directed table plus random stream.
`timescale 1ns / 1ps

module tb_ellipse_bounds_and_metrics;
  import elb_pkg::*;

  localparam int N_RANDOM = 1300;
  localparam int LATENCY = 51;
  localparam longint CYCLE_LIMIT = 400000;

  // One ellipse transaction
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] ax1;
    logic signed [31:0] ax2;
    logic [15:0]        az;
  } ellipse_t;

  // Directed row: stimulus, plus an optional typed-in result
  typedef struct {
    ellipse_t e;
    bit       fixed;
    res_t     r;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_center_x, in_center_y, in_axis_first, in_axis_second;
  logic [15:0] in_azimuth_in;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_box_x_min, out_box_x_max, out_box_y_min, out_box_y_max;
  logic [47:0] out_area_out;
  logic [33:0] out_perimeter_out;
  logic [30:0] out_focus_distance;
  logic [16:0] out_eccentricity_out;
  logic out_is_empty;
  logic [30:0] out_major_axis, out_minor_axis;
  logic [15:0] out_azimuth_out;

  res_t   expected_q[$];
  int     n_errors;
  longint n_cycles;
  bit     sender_done;
  bit     hold_sink;
  bit     sink_no_idle;

  ellipse_bounds_and_metrics dut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // |sin| of a binary angle by the polynomial approximation, Q16
  function automatic logic [63:0] sine_mag(logic [15:0] ang);
    logic [63:0] r, z, z2, inner, mid;
    r = {50'd0, ang[13:0]};
    if (ang[14]) r = 64'd16384 - r;
    z = r << 2;
    z2 = (z * z) >> 16;
    inner = 64'(C1_Q16) - ((z2 * 64'(C2_Q16)) >> 16);
    mid = 64'(PI_Q16) - ((z2 * inner) >> 16);
    return (z * mid + 64'd65536) >> 17;
  endfunction

  function automatic logic [63:0] axis_abs(logic signed [31:0] v);
    logic [63:0] m;
    m = v < 0 ? 64'(-64'(v)) : 64'(v);
    return m > 64'(AXIS_MAX) ? 64'(AXIS_MAX) : m;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Predicts the full metrics transaction for one ellipse
  function automatic res_t ellipse_metrics(ellipse_t e);
    res_t o;
    logic [63:0] a, b, t, s, c, as_, ac, bs, bc, hw, hh, t4, root, sum3, per, foc, ecc;
    logic [15:0] az;
    a = axis_abs(e.ax1);
    b = axis_abs(e.ax2);
    az = e.az;
    if (a < b) begin
      t = a; a = b; b = t;
      az = az + QUARTER_TURN;
    end
    o = '0;
    o.empty = (a == 0) || (b == 0);
    if (!o.empty) begin
      s = sine_mag(az);
      c = sine_mag(az + QUARTER_TURN);
      as_ = (a * s + 64'd32768) >> 16;
      ac = (a * c + 64'd32768) >> 16;
      bs = (b * s + 64'd32768) >> 16;
      bc = (b * c + 64'd32768) >> 16;
      hw = root64(as_ * as_ + bc * bc);
      hh = root64(ac * ac + bs * bs);
      o.box_x_min = clamp32(longint'(e.cx) - longint'(hw));
      o.box_x_max = clamp32(longint'(e.cx) + longint'(hw));
      o.box_y_min = clamp32(longint'(e.cy) - longint'(hh));
      o.box_y_max = clamp32(longint'(e.cy) + longint'(hh));
    end
    o.area = 48'((((a * b) >> 16) * 64'(PI_Q16) + 64'd32768) >> 16);
    t4 = ((a * b) >> 2) * 10 + ((a * a) >> 2) * 3 + ((b * b) >> 2) * 3;
    root = root64(t4) * 2;
    sum3 = 3 * (a + b);
    per = sum3 > root ? sum3 - root : 64'd0;
    per = (per * 64'(PI_Q16) + 64'd32768) >> 16;
    if (per > 64'h3_FFFF_FFFF) per = 64'h3_FFFF_FFFF;
    o.perimeter = 34'(per);
    foc = root64(a * a - b * b);
    ecc = o.empty ? 64'd0 : (foc << 16) / a;
    if (ecc > 64'd65536) ecc = 64'd65536;
    o.focus = 31'(foc);
    o.ecc = 17'(ecc);
    o.major = 31'(a);
    o.minor = 31'(b);
    o.az = az;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, field, got, want);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 4));
      3: return 32'($urandom_range(0, 32'h0040_0000)) * ($urandom_range(0, 1) ? 1 : -1);
      default: return 32'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  function automatic ellipse_t rand_ellipse();
    ellipse_t e;
    e.cx = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 32'h0400_0000));
    e.cy = $urandom_range(0, 3) == 0 ? 32'($urandom) : -32'($urandom_range(0, 32'h0400_0000));
    e.ax1 = rand_axis();
    e.ax2 = $urandom_range(0, 7) == 0 ? e.ax1 : rand_axis();
    e.az = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 4) * 16'h4000) : 16'($urandom);
    return e;
  endfunction

  // Offer one transaction and wait for acceptance; random idle before it
  task automatic send_ellipse(ellipse_t e, res_t want, bit allow_idle);
    while (allow_idle && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_center_x, in_center_y, in_axis_first, in_axis_second, in_azimuth_in} <= e;
    expected_q = {expected_q, want};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    res_t z;
    bit idle_ok;
    ellipse_t e;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_center_x, in_center_y, in_axis_first, in_axis_second, in_azimuth_in} = '0;
    sender_done = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ellipse: zero box and eccentricity, typed in
    z = '0;
    z.empty = 1'b1;
    rw.fixed = 1;
    rw.e = '{32'sd100, -32'sd7, 32'sd0, 32'sd0, 16'h1234};
    rw.r = z; rw.r.az = 16'h1234;
    rows = {rows, rw};
    rw.fixed = 0;
    rw.e = '{32'sd0, 32'sd0, 32'sh0001_0000, 32'sd0, 16'h0000}; rows = {rows, rw};
    rw.e = '{32'sd5, 32'sd5, 32'sd0, -32'sh0002_0000, 16'hFFFF}; rows = {rows, rw};
    // Circle, equal axes: no swap
    rw.e = '{32'sd0, 32'sd0, 32'sh0001_0000, 32'sh0001_0000, 16'h2000}; rows = {rows, rw};
    rw.e = '{32'sd0, 32'sd0, -32'sh0003_0000, 32'sh0003_0000, 16'h9000}; rows = {rows, rw};
    // Swap path and all quadrants
    rw.e = '{32'sd0, 32'sd0, 32'sh0001_0000, 32'sh0004_0000, 16'h0000}; rows = {rows, rw};
    rw.e = '{32'sd0, 32'sd0, 32'sh0004_0000, 32'sh0001_0000, 16'h4000}; rows = {rows, rw};
    rw.e = '{32'sd0, 32'sd0, 32'sh0004_0000, 32'sh0001_0000, 16'h8000}; rows = {rows, rw};
    rw.e = '{32'sd0, 32'sd0, 32'sh0004_0000, 32'sh0001_0000, 16'hC000}; rows = {rows, rw};
    rw.e = '{32'sd0, 32'sd0, 32'sh0004_0000, 32'sh0001_0000, 16'hFFFF}; rows = {rows, rw};
    // Most negative axes, saturating box edges
    rw.e = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'h1000};
    rows = {rows, rw};
    rw.e = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd1, 16'h6000};
    rows = {rows, rw};
    rw.e = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd1, 32'sh8000_0000, 16'hA5A5};
    rows = {rows, rw};
    rw.e = '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'h5A5A}; rows = {rows, rw};
    rw.e = '{32'sd0, 32'sd0, 32'sd1, 32'sd2, 16'h7FFF}; rows = {rows, rw};

    // Typed-in rows are checked against their own result, the rest against the predictor
    foreach (rows[i]) begin
      if (rows[i].fixed)
        send_ellipse(rows[i].e, rows[i].r, 1'b1);
      else
        send_ellipse(rows[i].e, ellipse_metrics(rows[i].e), 1'b1);
    end

    // Pause until drained
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);

    // Random stream; a stretch without idling overlaps the sink hold-off
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_ok = !(i >= 300 && i < 500);
      e = rand_ellipse();
      send_ellipse(e, ellipse_metrics(e), idle_ok);
    end
    in_valid <= 1'b0;
    sender_done = 1;
  end

  // Sink: random stalls, one long hold-off, one stretch with none
  initial begin
    int hold_count;
    out_ready = 1'b0;
    hold_sink = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_sink && expected_q.size() > 40 && hold_count == 0) begin
        hold_sink = 1;
        hold_count = 1;
      end
      if (hold_sink) begin
        hold_count++;
        if (hold_count > 150) hold_sink = 0;
      end
      sink_no_idle = (n_cycles > 1000 && n_cycles < 1500);
      out_ready <= !hold_sink && (sink_no_idle || $urandom_range(0, 99) >= 28);
    end
  end

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_box_x_min !== want.box_x_min)
          report_mismatch("box_x_min", out_box_x_min, want.box_x_min);
        if (out_box_x_max !== want.box_x_max)
          report_mismatch("box_x_max", out_box_x_max, want.box_x_max);
        if (out_box_y_min !== want.box_y_min)
          report_mismatch("box_y_min", out_box_y_min, want.box_y_min);
        if (out_box_y_max !== want.box_y_max)
          report_mismatch("box_y_max", out_box_y_max, want.box_y_max);
        if (out_area_out !== want.area)
          report_mismatch("area_out", out_area_out, want.area);
        if (out_perimeter_out !== want.perimeter)
          report_mismatch("perimeter_out", out_perimeter_out, want.perimeter);
        if (out_focus_distance !== want.focus)
          report_mismatch("focus_distance", out_focus_distance, want.focus);
        if (out_eccentricity_out !== want.ecc)
          report_mismatch("eccentricity_out", out_eccentricity_out, want.ecc);
        if (out_is_empty !== want.empty)
          report_mismatch("is_empty", out_is_empty, want.empty);
        if (out_major_axis !== want.major)
          report_mismatch("major_axis", out_major_axis, want.major);
        if (out_minor_axis !== want.minor)
          report_mismatch("minor_axis", out_minor_axis, want.minor);
        if (out_azimuth_out !== want.az)
          report_mismatch("azimuth_out", out_azimuth_out, want.az);
      end
    end
  end

  // End of run and timeout
  initial begin
    n_errors = 0;
    n_cycles = 0;
    while (!(sender_done && expected_q.size() == 0) && n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
    end else begin
      repeat (LATENCY * 2) @(posedge clk);
      if (n_errors == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule
